>>> design/arc_point_hit_test_core_macros.svh
// ----------------------------------------------------------------------------
// Arc point hit test - assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ARC_POINT_HIT_TEST_CORE_MACROS_SVH
`define ARC_POINT_HIT_TEST_CORE_MACROS_SVH

// same-cycle implication
`define APHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/apht_pkg.sv
// ----------------------------------------------------------------------------
// Arc point hit test - package
// Widths, register codes, CORDIC lane type and arctangent step table.
// ----------------------------------------------------------------------------
package apht_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int ANGLE_BITS    = 16;
  localparam int IDXW          = 5;    // stage index, up to 32 stages
  localparam int XW            = 36;   // CORDIC x/y datapath, signed
  localparam int ACCW          = 32;   // angle accumulator, 2^32 per turn
  localparam int CW            = 32;   // coordinate width
  localparam int DXW           = 33;   // point minus center
  localparam int LW            = 31;   // radius / tolerance width
  localparam int HIW           = XW - 1 - 16 + 32;
  localparam int LOW           = 16 + 32;
  localparam int SUMW          = HIW + 1;
  localparam int DW            = SUMW - 16;  // distance, Q20.16 unsigned

  localparam logic [31:0]     INV_GAIN  = 32'd2608131496;
  localparam logic [ACCW-1:0] HALF_TURN = ACCW'(64'h8000_0000);
  localparam logic [ACCW-1:0] DIR_ROUND = ACCW'(64'd1 << (31 - ANGLE_BITS));
  localparam logic [SUMW-1:0] DIST_RND  = SUMW'(64'h8000);

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4,
    REG_TOLERANCE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;   // point sits on the center
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic [ACCW-1:0]        acc;
  } lane_t;

  function automatic logic [ACCW-1:0] atan_step(input logic [IDXW-1:0] i);
    logic [ACCW-1:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/apht_prep.sv
// ----------------------------------------------------------------------------
// Arc point hit test - front end
// Offset from the center, then pre-rotation into the right half plane.
// ----------------------------------------------------------------------------
module apht_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             req_valid,
  input  logic signed [apht_pkg::CW-1:0]   point_x,
  input  logic signed [apht_pkg::CW-1:0]   point_y,
  input  logic signed [apht_pkg::CW-1:0]   center_x,
  input  logic signed [apht_pkg::CW-1:0]   center_y,
  output apht_pkg::lane_t                  lane_out
);

  logic                                v1_r;
  logic signed [apht_pkg::DXW-1:0]     dx_r, dx_nxt;
  logic signed [apht_pkg::DXW-1:0]     dy_r, dy_nxt;
  apht_pkg::lane_t                     lane_r, lane_nxt;
  logic signed [apht_pkg::XW-1:0]      dx_ext, dy_ext;

  assign dx_nxt = apht_pkg::DXW'(point_x) - apht_pkg::DXW'(center_x);
  assign dy_nxt = apht_pkg::DXW'(point_y) - apht_pkg::DXW'(center_y);

  assign dx_ext = apht_pkg::XW'(dx_r);
  assign dy_ext = apht_pkg::XW'(dy_r);

  // left half plane: negate and start half a turn around
  always_comb begin
    lane_nxt.valid = v1_r;
    lane_nxt.zero  = (dx_r == '0) && (dy_r == '0);
    if (dx_r[apht_pkg::DXW-1]) begin
      lane_nxt.x   = -dx_ext;
      lane_nxt.y   = -dy_ext;
      lane_nxt.acc = apht_pkg::HALF_TURN;
    end else begin
      lane_nxt.x   = dx_ext;
      lane_nxt.y   = dy_ext;
      lane_nxt.acc = '0;
    end
  end

  // only the valid bits are reset; the payload just follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      lane_r.valid <= 1'b0;
    end else if (en) begin
      v1_r         <= req_valid;
      lane_r       <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

>>> design/apht_cordic_cell.sv
// ----------------------------------------------------------------------------
// Arc point hit test - CORDIC cell
// One vectoring micro-rotation; the stage index sets shift and step angle.
// ----------------------------------------------------------------------------
module apht_cordic_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [apht_pkg::IDXW-1:0]       stage_idx,
  input  logic [apht_pkg::ACCW-1:0]       step_angle,
  input  apht_pkg::lane_t                 lane_in,
  output apht_pkg::lane_t                 lane_out
);

  apht_pkg::lane_t                 lane_r, lane_nxt;
  logic signed [apht_pkg::XW-1:0]  xs, ys;

  assign xs = lane_in.x >>> stage_idx;
  assign ys = lane_in.y >>> stage_idx;

  always_comb begin
    lane_nxt.valid = lane_in.valid;
    lane_nxt.zero  = lane_in.zero;
    if (!lane_in.y[apht_pkg::XW-1]) begin
      lane_nxt.x   = lane_in.x + ys;
      lane_nxt.y   = lane_in.y - xs;
      lane_nxt.acc = lane_in.acc + step_angle;
    end else begin
      lane_nxt.x   = lane_in.x - ys;
      lane_nxt.y   = lane_in.y + xs;
      lane_nxt.acc = lane_in.acc - step_angle;
    end
  end

  // only the valid bit is reset; the payload just follows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else if (en) begin
      lane_r       <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

>>> design/apht_post.sv
// ----------------------------------------------------------------------------
// Arc point hit test - back end
// Gain correction, direction rounding, sweep test and radial band test.
// ----------------------------------------------------------------------------
module apht_post (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  apht_pkg::lane_t                        lane_in,
  input  logic [apht_pkg::LW-1:0]                radius,
  input  logic [apht_pkg::LW-1:0]                tolerance,
  input  logic [apht_pkg::ANGLE_BITS-1:0]        start_angle,
  input  logic [apht_pkg::ANGLE_BITS-1:0]        end_angle,
  output logic                                   res_valid,
  output logic                                   res_hit
);

  localparam int AB = apht_pkg::ANGLE_BITS;

  // multiply stage
  logic                          vm_r;
  logic                          sweep_m_r, sweep_nxt;
  logic [apht_pkg::HIW-1:0]      hi_r, hi_nxt;
  logic [apht_pkg::LOW-1:0]      lo_r, lo_nxt;
  logic [apht_pkg::XW-2:0]       ux;
  logic [apht_pkg::ACCW-1:0]     acc_rnd;
  logic [AB-1:0]                 dir;

  // sum stage
  logic                          vd_r;
  logic                          sweep_d_r;
  logic [apht_pkg::SUMW-1:0]     sum;
  logic [apht_pkg::DW-1:0]       dist_r, dist_nxt;

  logic [apht_pkg::DW:0]         upper, lower;

  assign ux = (lane_in.zero || lane_in.x[apht_pkg::XW-1]) ? '0 :
              lane_in.x[apht_pkg::XW-2:0];

  // operands widened first so the products keep every bit
  assign hi_nxt = apht_pkg::HIW'(ux[apht_pkg::XW-2:16]) * apht_pkg::HIW'(apht_pkg::INV_GAIN);
  assign lo_nxt = apht_pkg::LOW'(ux[15:0]) * apht_pkg::LOW'(apht_pkg::INV_GAIN);

  assign acc_rnd = lane_in.acc + apht_pkg::DIR_ROUND;
  assign dir     = lane_in.zero ? '0 : acc_rnd[apht_pkg::ACCW-1 -: AB];

  // inclusive sweep, wrapping through zero when start is past end
  always_comb begin
    if (start_angle <= end_angle) begin
      sweep_nxt = (dir >= start_angle) && (dir <= end_angle);
    end else begin
      sweep_nxt = (dir >= start_angle) || (dir <= end_angle);
    end
  end

  assign sum = apht_pkg::SUMW'(hi_r) + apht_pkg::SUMW'(lo_r >> 16) + apht_pkg::DIST_RND;
  assign dist_nxt = sum[apht_pkg::SUMW-1:16];

  // |dist - radius| <= tol  as two one-sided compares
  assign upper = (apht_pkg::DW+1)'(radius) + (apht_pkg::DW+1)'(tolerance);
  assign lower = (apht_pkg::DW+1)'(dist_r) + (apht_pkg::DW+1)'(tolerance);

  assign res_valid = vd_r;
  assign res_hit   = sweep_d_r && ((apht_pkg::DW+1)'(dist_r) <= upper) &&
                     ((apht_pkg::DW+1)'(radius) <= lower);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      vm_r <= lane_in.valid;
      vd_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r      <= hi_nxt;
      lo_r      <= lo_nxt;
      sweep_m_r <= sweep_nxt;
      dist_r    <= dist_nxt;
      sweep_d_r <= sweep_m_r;
    end
  end

endmodule

>>> design/arc_point_hit_test_core.sv
// ----------------------------------------------------------------------------
// Arc point hit test - top level
// Tests one point per cycle, while in_ready is high, against a configured circular arc.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per point (in_point_x, in_point_y, signed Q16.16).
//   out_* : one response per request, out_hit = 1 when the point lies within
//           tolerance of the radius and inside the inclusive angular sweep.
//   cfg_* : register writes by index (center x/y, radius, start/end angle,
//           tolerance); always ready. Write only while no request is in flight.
// Pipeline: 2 front-end stages, one stage per CORDIC cell, 2 back-end stages,
//   then the output register.
// Throughput: one request per cycle; every stage is a register in the cell
//   chain, so the only limit is the receiver taking responses.
// Stall: a held response parks in the output register and one more in a skid
//   register; the chain freezes only once the skid register is full, and
//   in_ready is a registered signal, independent of out_ready.
// Reset: synchronous, active low; clears the chain valid bits, the output and
//   skid valid flags and the config registers (config registers reset to zero).
// ----------------------------------------------------------------------------
`include "arc_point_hit_test_core_macros.svh"

module arc_point_hit_test_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // point requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [apht_pkg::CW-1:0]    in_point_x,
  input  logic signed [apht_pkg::CW-1:0]    in_point_y,
  // hit responses
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int AB = apht_pkg::ANGLE_BITS;

  // configuration registers
  logic signed [apht_pkg::CW-1:0]  center_x_r;
  logic signed [apht_pkg::CW-1:0]  center_y_r;
  logic [apht_pkg::LW-1:0]         radius_r;
  logic [AB-1:0]                   start_angle_r;
  logic [AB-1:0]                   end_angle_r;
  logic [apht_pkg::LW-1:0]         tolerance_r;

  // chain advance: held only when both output slots are occupied
  logic                            en;
  apht_pkg::lane_t                 chain [apht_pkg::CORDIC_STAGES+1];
  logic                            tail_valid;
  logic                            tail_hit;
  logic                            res_valid;

  // output register plus skid register
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_hit_r, out_hit_nxt;
  logic                            sk_valid_r, sk_valid_nxt;
  logic                            sk_hit_r, sk_hit_nxt;
  logic                            slot_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      radius_r      <= '0;
      start_angle_r <= '0;
      end_angle_r   <= '0;
      tolerance_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        apht_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata;
        apht_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata;
        apht_pkg::REG_RADIUS:      radius_r      <= cfg_wdata[apht_pkg::LW-1:0];
        apht_pkg::REG_START_ANGLE: start_angle_r <= cfg_wdata[AB-1:0];
        apht_pkg::REG_END_ANGLE:   end_angle_r   <= cfg_wdata[AB-1:0];
        apht_pkg::REG_TOLERANCE:   tolerance_r   <= cfg_wdata[apht_pkg::LW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign en       = !sk_valid_r;
  assign in_ready = en;

  apht_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .req_valid (in_valid),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .lane_out  (chain[0])
  );

  // one vectoring micro-rotation per cell
  for (genvar i = 0; i < apht_pkg::CORDIC_STAGES; i++) begin : g_cell
    apht_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .stage_idx  (apht_pkg::IDXW'(i)),
      .step_angle (apht_pkg::atan_step(apht_pkg::IDXW'(i))),
      .lane_in    (chain[i]),
      .lane_out   (chain[i+1])
    );
  end

  apht_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .lane_in     (chain[apht_pkg::CORDIC_STAGES]),
    .radius      (radius_r),
    .tolerance   (tolerance_r),
    .start_angle (start_angle_r),
    .end_angle   (end_angle_r),
    .res_valid   (res_valid),
    .res_hit     (tail_hit)
  );

  // a result leaves the chain only on a cycle the chain advances
  assign tail_valid = en && res_valid;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    sk_valid_nxt  = sk_valid_r;
    sk_hit_nxt    = sk_hit_r;
    if (slot_free) begin
      if (sk_valid_r) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = sk_hit_r;
        sk_valid_nxt  = 1'b0;
      end else begin
        out_valid_nxt = tail_valid;
        out_hit_nxt   = tail_hit;
      end
    end else if (tail_valid) begin
      sk_valid_nxt = 1'b1;
      sk_hit_nxt   = tail_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sk_valid_r  <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    sk_hit_r  <= sk_hit_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `APHT_ASSERT_NOW(a_skid_behind_out, sk_valid_r, out_valid_r, "skid filled with output empty")
  `APHT_ASSERT_NOW(a_skid_blocks_in, sk_valid_r, !in_ready, "request taken while skid full")
  `APHT_ASSERT_NEXT(a_park_in_skid, out_valid_r && !out_ready && tail_valid, sk_valid_r,
                    "stalled result not parked")

endmodule

>>> tb/sv/tb_arc_point_hit_test_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Arc point hit test - testbench
// Sends points to the core and checks each hit flag against an in-bench
// model of the arc: a CORDIC-based distance and direction, then the radial
// and sweep tests. Directed checks cover the register edges, the sweep ends,
// equal start/end angles and the center point. Randomized phases follow,
// each with its own arc setting, and one phase holds the receiver off long
// enough to fill the pipe. Both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_arc_point_hit_test_core;

  // Q16.16 helpers and register extremes
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] LEN_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] ANG_MAX   = 32'h0000_FFFF;
  localparam logic [31:0] ANG_HALF  = 32'h0000_8000;
  localparam logic [31:0] ANG_QUART = 32'h0000_4000;

  // indexes past the register list; writes there must be dropped
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // cycles with no accepted request of any kind before the run is called hung;
  // the longest deliberate hold-off is HOLD_CYCLES, well below this limit
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;   // longer than the pipeline latency
  localparam int PHASES = 12;
  localparam int POINTS_PER_PHASE = 112;

  // arctangent steps, 2^32 units per turn
  localparam bit [31:0] CORDIC_ATAN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic               out_valid;
  logic               out_ready;
  logic               out_hit;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  // arc as the bench believes it is programmed
  longint                           arc_cx;
  longint                           arc_cy;
  longint                           arc_radius;
  longint                           arc_tol;
  bit [apht_pkg::ANGLE_BITS-1:0]    arc_start;
  bit [apht_pkg::ANGLE_BITS-1:0]    arc_end;

  bit  expected_hits[$];   // predicted flags, oldest first
  int  mismatches;
  int  quiet_cycles;
  bit  tx_idle_en;         // sender inserts gaps
  bit  rx_idle_en;         // receiver stalls at random
  int  hold_req;           // long receiver hold-off, picked up by the receiver

  arc_point_hit_test_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Arc model
  // --------------------------------------------------------------------------

  // register write as the core applies it: extra high bits are dropped,
  // unknown indexes do nothing
  function automatic void arc_reg_write(logic [2:0] idx, logic [31:0] d);
    case (idx)
      apht_pkg::REG_CENTER_X:    arc_cx = longint'(signed'(d));
      apht_pkg::REG_CENTER_Y:    arc_cy = longint'(signed'(d));
      apht_pkg::REG_RADIUS:      arc_radius = longint'({33'd0, d[30:0]});
      apht_pkg::REG_START_ANGLE: arc_start = d[apht_pkg::ANGLE_BITS-1:0];
      apht_pkg::REG_END_ANGLE:   arc_end = d[apht_pkg::ANGLE_BITS-1:0];
      apht_pkg::REG_TOLERANCE:   arc_tol = longint'({33'd0, d[30:0]});
      default: ;
    endcase
  endfunction

  // hit flag for one point against the current arc
  function automatic bit predict_hit(logic [31:0] px, logic [31:0] py);
    longint                        dx, dy, x, y, xs, ys, radial, err;
    bit [31:0]                     acc;
    bit [63:0]                     ux, hi, lo;
    bit [apht_pkg::ANGLE_BITS-1:0] dir;
    bit                            in_arc;
    int                            i;
    dx = longint'(signed'(px)) - arc_cx;
    dy = longint'(signed'(py)) - arc_cy;
    radial = 0;
    dir = '0;
    // the center itself skips the CORDIC: distance 0, direction 0
    if (dx != 0 || dy != 0) begin
      x = dx;
      y = dy;
      acc = '0;
      // left half plane: rotate by a half turn first
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h8000_0000;
      end
      for (i = 0; i < apht_pkg::CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          acc = acc + CORDIC_ATAN[i];
        end else begin
          x = x - ys;
          y = y + xs;
          acc = acc - CORDIC_ATAN[i];
        end
      end
      // gain correction, rounded half up
      ux = (x < 0) ? 64'd0 : 64'(x);
      hi = (ux >> 16) * 64'd2608131496;
      lo = (ux & 64'hFFFF) * 64'd2608131496;
      radial = longint'((hi + (lo >> 16) + 64'h8000) >> 16);
      acc = acc + (32'd1 << (31 - apht_pkg::ANGLE_BITS));
      dir = acc[31 -: apht_pkg::ANGLE_BITS];
    end
    err = radial - arc_radius;
    if (err < 0) err = -err;
    // inclusive sweep, wrapping through zero when start > end
    if (arc_start <= arc_end) in_arc = (dir >= arc_start) && (dir <= arc_end);
    else in_arc = (dir >= arc_start) || (dir <= arc_end);
    return (err <= arc_tol) && in_arc;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one point request; valid stays up into the next request when there is no gap
  task automatic send_point(input logic [31:0] px, input logic [31:0] py);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (!in_ready);
    expected_hits.push_back(predict_hit(px, py));
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    arc_reg_write(idx, d);
  endtask

  task automatic set_arc(input logic [31:0] cx, input logic [31:0] cy,
                         input logic [31:0] r, input logic [31:0] sa,
                         input logic [31:0] ea, input logic [31:0] tol);
    write_reg(apht_pkg::REG_CENTER_X, cx);
    write_reg(apht_pkg::REG_CENTER_Y, cy);
    write_reg(apht_pkg::REG_RADIUS, r);
    write_reg(apht_pkg::REG_START_ANGLE, sa);
    write_reg(apht_pkg::REG_END_ANGLE, ea);
    write_reg(apht_pkg::REG_TOLERANCE, tol);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and let every outstanding response come back
  task automatic wait_all_hits();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  // random point: mostly close to the arc, the rest spread or near the center
  function automatic void pick_point(output logic [31:0] px, output logic [31:0] py);
    int     sel;
    bit [apht_pkg::ANGLE_BITS-1:0] span, a;
    real    th, rr;
    longint lx, ly;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      span = arc_end - arc_start;
      if ($urandom_range(0, 9) < 8)
        a = arc_start + apht_pkg::ANGLE_BITS'($urandom_range(0, span));
      else a = apht_pkg::ANGLE_BITS'($urandom_range(0, 65535));
      th = real'(a) * 6.283185307179586 / 65536.0;
      rr = real'(arc_radius)
           + (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 1.5 * real'(arc_tol)
           + real'($urandom_range(0, 6)) - 3.0;
      lx = arc_cx + longint'(rr * $cos(th));
      ly = arc_cy + longint'(rr * $sin(th));
      px = lx[31:0];
      py = ly[31:0];
    end else if (sel < 80) begin
      px = $urandom;
      py = $urandom;
    end else if (sel < 90) begin
      lx = arc_cx + longint'($urandom_range(0, 14)) - 7;
      ly = arc_cy + longint'($urandom_range(0, 14)) - 7;
      px = lx[31:0];
      py = ly[31:0];
    end else begin
      // on the center or on one of its axes
      lx = arc_cx;
      ly = arc_cy;
      if ($urandom_range(0, 2) == 0) lx = lx + longint'(signed'($urandom)) / 4;
      else if ($urandom_range(0, 1) == 0) ly = ly + longint'(signed'($urandom)) / 4;
      px = lx[31:0];
      py = ly[31:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset arc: center 0, radius 0, tolerance 0, sweep of the single angle 0
  task automatic test_reset_state();
    send_point(32'd0, 32'd0);          // center: distance 0, direction 0 -> hit
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(32'd1, 32'd0);
    wait_all_hits();
  endtask

  // ignored indexes, oversized values, and the widest point offsets
  task automatic test_register_edges();
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'h1234_5678);
    cfg_valid <= 1'b0;
    send_point(32'd0, 32'd0);
    wait_all_hits();
    // high bits of radius, tolerance and the angles must drop out
    set_arc(COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 32'hABCD_C000, 32'h1234_4000,
            32'h8000_0005);
    send_point(COORD_MAX, COORD_MIN);  // both offsets at full 33-bit reach
    send_point(COORD_MAX, COORD_MAX);
    wait_all_hits();
  endtask

  // both sweep ends are inside, radial band is inclusive
  task automatic test_sweep_ends();
    set_arc(32'd0, 32'd0, 32'd6553600, 32'd0, ANG_QUART, Q_ONE);
    send_point(32'd6553600, 32'd0);
    send_point(32'd0, 32'd6553600);
    send_point(-32'sd6553600, 32'd0);
    send_point(32'd0, -32'sd6553600);
    send_point(32'd6619136, 32'd0);    // right on the outer edge of the band
    send_point(32'd6619137, 32'd0);
    send_point(32'd4634400, 32'd4634400);
    wait_all_hits();
  endtask

  // start == end: only that one direction counts
  task automatic test_equal_angles();
    set_arc(32'd1000, -32'sd1000, 32'd3276800, 32'd0, 32'd0, 32'd131072);
    send_point(32'd3277800, -32'sd1000);
    send_point(32'd3277800, -32'sd999);
    send_point(32'd1000, -32'sd1000);
    wait_all_hits();
    // center point has direction 0, outside a half-turn-only sweep
    set_arc(32'd1000, -32'sd1000, 32'd0, ANG_HALF, ANG_HALF, 32'd8);
    send_point(32'd1000, -32'sd1000);
    send_point(32'd995, -32'sd1000);
    wait_all_hits();
  endtask

  // one arc setting per phase, extremes spread over the phases
  task automatic test_random_arcs();
    logic [31:0] cx, cy, r, sa, ea, tol, px, py;
    int k, n;
    for (k = 0; k < PHASES; k++) begin
      cx  = signed'($urandom) >>> $urandom_range(1, 12);
      cy  = signed'($urandom) >>> $urandom_range(1, 12);
      r   = $urandom >> $urandom_range(1, 20);
      tol = r >> $urandom_range(2, 12);
      sa  = $urandom_range(0, 65535);
      ea  = $urandom_range(0, 65535);
      case (k)
        1: begin sa = 32'd0; ea = ANG_MAX; end
        2: ea = sa;
        3: begin r = LEN_MAX; cx = 32'd0; cy = 32'd0; end
        5: tol = LEN_MAX;
        6: tol = 32'd0;
        7: begin sa = ANG_MAX; ea = 32'd0; end
        9: begin cx = COORD_MAX; cy = COORD_MIN; end
        10: begin r = 32'd0; tol = $urandom_range(0, 64); end
        default: ;
      endcase
      // every fourth phase runs with no idling on either side
      tx_idle_en = (k % 4 != 0);
      rx_idle_en = (k % 4 != 0) && (k % 4 != 2);
      set_arc(cx, cy, r, sa, ea, tol);
      for (n = 0; n < POINTS_PER_PHASE; n++) begin
        pick_point(px, py);
        send_point(px, py);
      end
      wait_all_hits();
    end
  endtask

  // receiver holds off while points keep coming, so the pipe fills and
  // in_ready has to drop
  task automatic test_backpressure();
    logic [31:0] px, py;
    int n;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = HOLD_CYCLES;
    for (n = 0; n < 80; n++) begin
      pick_point(px, py);
      send_point(px, py);
    end
    wait_all_hits();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // out_ready: random stalls, or one long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare every accepted response with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending, hit=%b", out_hit));
      end else begin
        if (out_hit !== expected_hits[0])
          report_mismatch($sformatf("hit=%b, predicted %b", out_hit, expected_hits[0]));
        void'(expected_hits.pop_front());
      end
    end
  end

  // hang detection: any accepted request on any port resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    mismatches = 0;
    hold_req = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // model starts from the reset arc
    arc_cx = 0;
    arc_cy = 0;
    arc_radius = 0;
    arc_tol = 0;
    arc_start = '0;
    arc_end = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_edges();
    test_sweep_ends();
    test_equal_angles();
    test_random_arcs();
    test_backpressure();

    wait_all_hits();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> arc_point_hit_test_core.f
+incdir+design
design/apht_pkg.sv
design/apht_prep.sv
design/apht_cordic_cell.sv
design/apht_post.sv
design/arc_point_hit_test_core.sv
tb/sv/tb_arc_point_hit_test_core.sv
